FILE: rtl/core/conv2d_reflect_border_core_macros.svh
// assertion helpers for the convolution core checker
`ifndef CONV2D_REFLECT_BORDER_CORE_MACROS_SVH
`define CONV2D_REFLECT_BORDER_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define C2DRB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("c2drb port check failed");

// next-cycle implication, sampled on the rising clock edge
`define C2DRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("c2drb port check failed");

`endif

FILE: rtl/core/c2drb_pkg.sv
`timescale 1ns / 1ps

package c2drb_pkg;

  // store geometry
  localparam int LINES      = 8;
  localparam int MAX_COLS   = 2048;
  localparam int CHANNELS   = 4;
  localparam int MAX_KERNEL = 5;

  localparam int STORE_DEPTH = LINES * MAX_COLS * CHANNELS;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CHAN_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // kernel geometry
  localparam int MAX_HALF = MAX_KERNEL / 2;
  localparam int HALF_W   = $clog2(MAX_HALF + 1);
  localparam int KIDX_W   = $clog2(MAX_KERNEL);

  // field widths
  localparam int ROW_IN_W = 12;
  localparam int COL_IN_W = 11;
  localparam int CH_IN_W  = 2;
  localparam int PIX_W    = 8;
  localparam int ROW_W    = 13;  // reflected row, clamped below the image row count
  localparam int COL_W    = 12;  // reflected column
  localparam int COEF_W   = 12;
  localparam int COEF_ROWS = 5;
  localparam int COEF_ROW_W = COEF_ROWS * COEF_W;
  localparam int PROD_W   = PIX_W + 1 + COEF_W;
  localparam int SUM_W    = 25;

  // configuration registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_ROW_W;
  localparam int IMG_ROWS_W = 13;
  localparam int IMG_COLS_W = 12;
  localparam int KSIZE_W    = 3;

  localparam logic [IMG_ROWS_W-1:0] IMG_ROWS_RST = IMG_ROWS_W'(480);
  localparam logic [IMG_COLS_W-1:0] IMG_COLS_RST = IMG_COLS_W'(640);
  localparam logic [KSIZE_W-1:0]    KSIZE_RST    = KSIZE_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_ROWS  = 3'd0,
    CFG_IMAGE_COLS  = 3'd1,
    CFG_KERNEL_SIZE = 3'd2,
    CFG_COEF_ROW_0  = 3'd3,
    CFG_COEF_ROW_1  = 3'd4,
    CFG_COEF_ROW_2  = 3'd5,
    CFG_COEF_ROW_3  = 3'd6,
    CFG_COEF_ROW_4  = 3'd7
  } cfg_idx_e;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_SUM   = 1'b1;

  // control that travels with every store access
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic              first;
    logic              last;
    logic [KIDX_W-1:0] kr;
    logic [KIDX_W-1:0] kc;
  } tap_meta_t;

endpackage

FILE: rtl/core/c2drb_tapgen.sv
`timescale 1ns / 1ps

module c2drb_tapgen import c2drb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  kind_i,
  input  logic [ROW_IN_W-1:0]   row_i,
  input  logic [COL_IN_W-1:0]   col_i,
  input  logic [CH_IN_W-1:0]    channel_i,
  input  logic [PIX_W-1:0]      pixel_i,
  input  logic [IMG_ROWS_W-1:0] image_rows_i,
  input  logic [IMG_COLS_W-1:0] image_cols_i,
  input  logic [KSIZE_W-1:0]    kernel_size_i,
  output logic                  busy_o,
  output tap_meta_t             meta_o,
  output logic [ROW_W-1:0]      rrow_o,
  output logic [COL_W-1:0]      rcol_o,
  output logic [CH_IN_W-1:0]    chan_o,
  output logic [PIX_W-1:0]      pix_o
);

  // border reflection with the edge repeated, then clamped into the image
  function automatic logic [ROW_W-1:0] reflect(input logic signed [15:0] idx,
                                               input logic [ROW_W-1:0] size);
    logic signed [15:0] n;
    logic signed [15:0] r;
    n = (size == '0) ? 16'sd1 : $signed(16'(size));
    if (idx < 16'sd0) begin
      r = -idx - 16'sd1;
    end else if (idx >= n) begin
      r = (n <<< 1) - 16'sd1 - idx;
    end else begin
      r = idx;
    end
    if (r < 16'sd0) begin
      r = 16'sd0;
    end
    if (r >= n) begin
      r = n - 16'sd1;
    end
    return ROW_W'(r);
  endfunction

  logic                 active_q, active_d;
  logic [ROW_IN_W-1:0]  anc_row_q, anc_row_d;
  logic [COL_IN_W-1:0]  anc_col_q, anc_col_d;
  logic [HALF_W-1:0]    half_q, half_d;
  logic [KIDX_W-1:0]    kr_q, kr_d;
  logic [KIDX_W-1:0]    kc_q, kc_d;
  tap_meta_t            meta_q, meta_d;
  logic [ROW_W-1:0]     rrow_q, rrow_d;
  logic [COL_W-1:0]     rcol_q, rcol_d;
  logic [CH_IN_W-1:0]   chan_q, chan_d;
  logic [PIX_W-1:0]     pix_q, pix_d;

  logic [KIDX_W-1:0]    span;
  logic                 last_tap;
  logic signed [15:0]   ti, tj;
  logic [KSIZE_W-1:0]   ks_half;

  assign span     = KIDX_W'({half_q, 1'b0});
  assign last_tap = (kr_q == span) && (kc_q == span);
  assign ti = $signed(16'(anc_row_q)) + $signed(16'(kr_q)) - $signed(16'(half_q));
  assign tj = $signed(16'(anc_col_q)) + $signed(16'(kc_q)) - $signed(16'(half_q));
  assign ks_half = kernel_size_i >> 1;

  // tap sequencing: one window tap a cycle, row by row
  always_comb begin
    active_d  = active_q;
    anc_row_d = anc_row_q;
    anc_col_d = anc_col_q;
    half_d    = half_q;
    kr_d      = kr_q;
    kc_d      = kc_q;
    meta_d    = '0;
    rrow_d    = rrow_q;
    rcol_d    = rcol_q;
    chan_d    = chan_q;
    pix_d     = pix_q;
    if (active_q) begin
      meta_d.rd    = 1'b1;
      meta_d.first = (kr_q == '0) && (kc_q == '0);
      meta_d.last  = last_tap;
      meta_d.kr    = kr_q;
      meta_d.kc    = kc_q;
      rrow_d = reflect(ti, ROW_W'(image_rows_i));
      rcol_d = COL_W'(reflect(tj, ROW_W'(image_cols_i)));
      if (kc_q == span) begin
        kc_d = '0;
        kr_d = kr_q + KIDX_W'(1);
      end else begin
        kc_d = kc_q + KIDX_W'(1);
      end
      if (last_tap) begin
        active_d = 1'b0;
      end
    end else if (start_i) begin
      chan_d = channel_i;
      if (kind_i == KIND_WRITE) begin
        meta_d.wr = 1'b1;
        rrow_d    = ROW_W'(row_i);
        rcol_d    = COL_W'(col_i);
        pix_d     = pixel_i;
      end else begin
        active_d  = 1'b1;
        anc_row_d = row_i;
        anc_col_d = col_i;
        half_d    = (ks_half > KSIZE_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : HALF_W'(ks_half);
        kr_d      = '0;
        kc_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      meta_q   <= '0;
      half_q   <= '0;
      kr_q     <= '0;
      kc_q     <= '0;
    end else begin
      active_q <= active_d;
      meta_q   <= meta_d;
      half_q   <= half_d;
      kr_q     <= kr_d;
      kc_q     <= kc_d;
    end
  end

  // payload of the tap and the anchor
  always_ff @(posedge clk_i) begin
    anc_row_q <= anc_row_d;
    anc_col_q <= anc_col_d;
    rrow_q    <= rrow_d;
    rcol_q    <= rcol_d;
    chan_q    <= chan_d;
    pix_q     <= pix_d;
  end

  assign busy_o = active_q;
  assign meta_o = meta_q;
  assign rrow_o = rrow_q;
  assign rcol_o = rcol_q;
  assign chan_o = chan_q;
  assign pix_o  = pix_q;

endmodule

FILE: rtl/core/c2drb_addr.sv
`timescale 1ns / 1ps

module c2drb_addr import c2drb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tap_meta_t          meta_i,
  input  logic [ROW_W-1:0]   rrow_i,
  input  logic [COL_W-1:0]   rcol_i,
  input  logic [CH_IN_W-1:0] chan_i,
  input  logic [PIX_W-1:0]   pix_i,
  output tap_meta_t          meta_o,
  output logic [AW-1:0]      addr_o,
  output logic [PIX_W-1:0]   pix_o
);

  // reciprocal constants for the ring line and column wrap
  localparam int LINE_W  = $clog2(LINES);
  localparam int LINE_SH = ROW_W + LINE_W;
  localparam int LINE_MW = ROW_W + 2;
  localparam int LINE_PW = ROW_W + LINE_MW;
  localparam logic [LINE_MW-1:0] LINE_M = LINE_MW'((2 ** LINE_SH + LINES - 1) / LINES);

  localparam int CW_W   = $clog2(MAX_COLS);
  localparam int COL_SH = COL_W + CW_W;
  localparam int COL_MW = COL_W + 2;
  localparam int COL_PW = COL_W + COL_MW;
  localparam logic [COL_MW-1:0] COL_M = COL_MW'((2 ** COL_SH + MAX_COLS - 1) / MAX_COLS);

  localparam logic [AW-1:0] LINE_STRIDE = AW'(MAX_COLS * CHANNELS);

  // channel wrap by repeated subtraction on a narrow value
  function automatic logic [CHAN_W-1:0] chan_wrap(input logic [CH_IN_W-1:0] ch);
    logic [CH_IN_W:0] v;
    v = (CH_IN_W + 1)'(ch);
    for (int k = 0; k < 4; k++) begin
      if (v >= (CH_IN_W + 1)'(CHANNELS)) begin
        v = v - (CH_IN_W + 1)'(CHANNELS);
      end
    end
    return CHAN_W'(v);
  endfunction

  tap_meta_t           meta_a_q, meta_b_q, meta_c_q;
  logic [ROW_W-1:0]    rrow_a_q, qrow_a_q;
  logic [COL_W-1:0]    rcol_a_q, qcol_a_q;
  logic [CHAN_W-1:0]   chw_a_q, chw_b_q;
  logic [PIX_W-1:0]    pix_a_q, pix_b_q, pix_c_q;
  logic [LINE_W-1:0]   line_b_q;
  logic [CW_W-1:0]     cw_b_q;
  logic [AW-1:0]       addr_c_q;

  logic [ROW_W-1:0]    qrow_d, rem_row, line_d;
  logic [COL_W-1:0]    qcol_d, rem_col, cw_d;
  logic [AW-1:0]       addr_d;

  // stage a: quotient by reciprocal multiplication
  assign qrow_d = ROW_W'((LINE_PW'(rrow_i) * LINE_PW'(LINE_M)) >> LINE_SH);
  assign qcol_d = COL_W'((COL_PW'(rcol_i) * COL_PW'(COL_M)) >> COL_SH);

  // stage b: remainder with one correction step
  assign rem_row = rrow_a_q - ROW_W'(qrow_a_q * ROW_W'(LINES));
  assign rem_col = rcol_a_q - COL_W'(qcol_a_q * COL_W'(MAX_COLS));
  assign line_d  = (rem_row >= ROW_W'(LINES)) ? rem_row - ROW_W'(LINES) : rem_row;
  assign cw_d    = (rem_col >= COL_W'(MAX_COLS)) ? rem_col - COL_W'(MAX_COLS) : rem_col;

  // stage c: flat store address, line then column then channel
  assign addr_d = AW'(line_b_q) * LINE_STRIDE + AW'(cw_b_q) * AW'(CHANNELS) + AW'(chw_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_a_q <= '0;
      meta_b_q <= '0;
      meta_c_q <= '0;
    end else begin
      meta_a_q <= meta_i;
      meta_b_q <= meta_a_q;
      meta_c_q <= meta_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rrow_a_q <= rrow_i;
    qrow_a_q <= qrow_d;
    rcol_a_q <= rcol_i;
    qcol_a_q <= qcol_d;
    chw_a_q  <= chan_wrap(chan_i);
    pix_a_q  <= pix_i;
    line_b_q <= LINE_W'(line_d);
    cw_b_q   <= CW_W'(cw_d);
    chw_b_q  <= chw_a_q;
    pix_b_q  <= pix_a_q;
    addr_c_q <= addr_d;
    pix_c_q  <= pix_b_q;
  end

  assign meta_o = meta_c_q;
  assign addr_o = addr_c_q;
  assign pix_o  = pix_c_q;

endmodule

FILE: rtl/core/c2drb_ram.sv
`timescale 1ns / 1ps

module c2drb_ram import c2drb_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [PIX_W-1:0] wdata_i,
  output logic [PIX_W-1:0] rdata_o
);

  logic [PIX_W-1:0] mem_q [STORE_DEPTH];
  logic [PIX_W-1:0] rdata_q;

  // single port line store, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/c2drb_mac.sv
`timescale 1ns / 1ps

module c2drb_mac import c2drb_pkg::*; (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tap_meta_t                             meta_i,
  input  logic [PIX_W-1:0]                      rdata_i,
  input  logic [COEF_ROWS-1:0][COEF_ROW_W-1:0]  coef_i,
  output logic signed [SUM_W-1:0]               sum_o,
  output logic                                  done_o
);

  tap_meta_t                 meta_r_q;
  logic                      prod_vld_q, prod_first_q, prod_last_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [SUM_W-1:0]   acc_q, acc_d;
  logic signed [SUM_W-1:0]   sum_q;
  logic                      done_q;
  logic signed [COEF_W-1:0]  coef_sel;
  logic signed [PROD_W-1:0]  px_s, coef_s;

  // coefficient of the tap that the store is returning
  assign coef_sel = $signed(coef_i[meta_r_q.kr][COEF_W * meta_r_q.kc +: COEF_W]);
  assign px_s     = $signed(PROD_W'(rdata_i));
  assign coef_s   = PROD_W'(coef_sel);
  assign prod_d   = PROD_W'(px_s * coef_s);

  // accumulate, restart on the first tap of a window
  assign acc_d = prod_first_q ? SUM_W'(prod_q) : acc_q + SUM_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_r_q     <= '0;
      prod_vld_q   <= 1'b0;
      prod_first_q <= 1'b0;
      prod_last_q  <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      meta_r_q     <= meta_i;
      prod_vld_q   <= meta_r_q.rd;
      prod_first_q <= meta_r_q.rd & meta_r_q.first;
      prod_last_q  <= meta_r_q.rd & meta_r_q.last;
      done_q       <= prod_vld_q & prod_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (prod_vld_q) begin
      acc_q <= acc_d;
    end
    if (prod_vld_q && prod_last_q) begin
      sum_q <= acc_d;
    end
  end

  assign sum_o  = sum_q;
  assign done_o = done_q;

endmodule

FILE: rtl/core/conv2d_reflect_border_core.sv
`timescale 1ns / 1ps
// pixel write: one beat per cycle while not busy, stored via the tap and address stages
// window sum: one read per tap, (2h+1)^2 taps, h = min(k/2, 2); no new item while busy
// busy holds while taps issue; the strobe follows through address, store and MAC stages
// single-port line store sets the rate; taps and writes share its one port
// reset clears control and configuration, the line store holds no reset value

module conv2d_reflect_border_core import c2drb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    kind_i,
  input  logic [ROW_IN_W-1:0]     row_i,
  input  logic [COL_IN_W-1:0]     col_i,
  input  logic [CH_IN_W-1:0]      channel_i,
  input  logic [PIX_W-1:0]        pixel_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output logic signed [SUM_W-1:0] weighted_sum_o,
  output logic                    done_o
);

  logic [IMG_ROWS_W-1:0]                 image_rows_q;
  logic [IMG_COLS_W-1:0]                 image_cols_q;
  logic [KSIZE_W-1:0]                    kernel_size_q;
  logic [COEF_ROWS-1:0][COEF_ROW_W-1:0]  coef_q;

  tap_meta_t           tap_meta, st_meta;
  logic [ROW_W-1:0]    tap_rrow;
  logic [COL_W-1:0]    tap_rcol;
  logic [CH_IN_W-1:0]  tap_chan;
  logic [PIX_W-1:0]    tap_pix, st_pix, st_rdata;
  logic [AW-1:0]       st_addr;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_rows_q  <= IMG_ROWS_RST;
      image_cols_q  <= IMG_COLS_RST;
      kernel_size_q <= KSIZE_RST;
      coef_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_ROWS:  image_rows_q  <= IMG_ROWS_W'(cfg_data_i);
        CFG_IMAGE_COLS:  image_cols_q  <= IMG_COLS_W'(cfg_data_i);
        CFG_KERNEL_SIZE: kernel_size_q <= KSIZE_W'(cfg_data_i);
        CFG_COEF_ROW_0:  coef_q[0]     <= cfg_data_i;
        CFG_COEF_ROW_1:  coef_q[1]     <= cfg_data_i;
        CFG_COEF_ROW_2:  coef_q[2]     <= cfg_data_i;
        CFG_COEF_ROW_3:  coef_q[3]     <= cfg_data_i;
        CFG_COEF_ROW_4:  coef_q[4]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // tap sequencer with border reflection
  c2drb_tapgen u_tapgen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .kind_i        (kind_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .channel_i     (channel_i),
    .pixel_i       (pixel_i),
    .image_rows_i  (image_rows_q),
    .image_cols_i  (image_cols_q),
    .kernel_size_i (kernel_size_q),
    .busy_o        (busy),
    .meta_o        (tap_meta),
    .rrow_o        (tap_rrow),
    .rcol_o        (tap_rcol),
    .chan_o        (tap_chan),
    .pix_o         (tap_pix)
  );

  // ring line and column wrap into a flat address
  c2drb_addr u_addr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .meta_i (tap_meta),
    .rrow_i (tap_rrow),
    .rcol_i (tap_rcol),
    .chan_i (tap_chan),
    .pix_i  (tap_pix),
    .meta_o (st_meta),
    .addr_o (st_addr),
    .pix_o  (st_pix)
  );

  // line store
  c2drb_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (st_meta.wr),
    .addr_i  (st_addr),
    .wdata_i (st_pix),
    .rdata_o (st_rdata)
  );

  // multiply and accumulate
  c2drb_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .meta_i  (st_meta),
    .rdata_i (st_rdata),
    .coef_i  (coef_q),
    .sum_o   (weighted_sum_o),
    .done_o  (done_o)
  );

endmodule

FILE: rtl/core/c2drb_checker.sv
`timescale 1ns / 1ps
`include "conv2d_reflect_border_core_macros.svh"

module c2drb_checker import c2drb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic kind_i,
  input logic done_o
);

  // a window sum holds the block busy in the next cycle
  `C2DRB_ASSERT_NEXT(a_sum_sets_busy, start && !busy && kind_i == KIND_SUM, busy)
  // a pixel write never blocks the following beat
  `C2DRB_ASSERT_NEXT(a_write_keeps_free, start && !busy && kind_i == KIND_WRITE, !busy)
  // two results are never strobed back to back
  `C2DRB_ASSERT_NEXT(a_done_single, done_o, !done_o)
  // busy is seen in the cycle after a window sum beat is taken
  `C2DRB_ASSERT_SAME(a_busy_after_sum, $past(start && !busy && kind_i == KIND_SUM), busy)

endmodule

bind conv2d_reflect_border_core c2drb_checker u_checker (.*);

FILE: tb/sv/conv2d_reflect_border_core_test.sv
`timescale 1ns / 1ps

module conv2d_reflect_border_core_test;
  import c2drb_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 210;

  typedef enum int {DOP_PIXEL, DOP_SUM, DOP_REG} dir_op_e;
  typedef enum int {COEF_RANDOM, COEF_ALL_MAX, COEF_ALL_MIN, COEF_MIXED} coef_mode_e;

  typedef struct {
    dir_op_e         op;
    int              row;
    int              col;
    int              ch;
    int              pix;
    cfg_idx_e        idx;
    logic [59:0]     data;
    bit              typed;
    int              sum;
  } dir_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    kind_i;
  logic [ROW_IN_W-1:0]     row_i;
  logic [COL_IN_W-1:0]     col_i;
  logic [CH_IN_W-1:0]      channel_i;
  logic [PIX_W-1:0]        pixel_i;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic signed [SUM_W-1:0] weighted_sum_o;
  logic                    done_o;

  // predictor state: line store image and register copies
  bit [7:0]             pix_mem   [0:STORE_DEPTH-1];
  bit                   pix_valid [0:STORE_DEPTH-1];
  int                   img_rows;
  int                   img_cols;
  int                   kernel_sz;
  logic [COEF_ROW_W-1:0] kern_rows [0:COEF_ROWS-1];

  logic signed [SUM_W-1:0] pending_sums [$];
  logic signed [SUM_W-1:0] oldest_sum;
  dir_row_t                dir_rows [$];

  int  mismatch_count;
  int  items_total;
  int  pixel_writes;
  int  window_sums;
  int  sums_checked;
  int  settings_run;
  int  burst_left;
  int  cycle_count;
  bit  work_since_idle;

  conv2d_reflect_border_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .channel_i      (channel_i),
    .pixel_i        (pixel_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .weighted_sum_o (weighted_sum_o),
    .done_o         (done_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // border reflection with the edge pixel repeated, then clamped
  function automatic int reflect_index(int i, int size);
    int n;
    int r;
    n = (size == 0) ? 1 : size;
    r = i;
    if (i < 0) begin
      r = -i - 1;
    end else if (i >= n) begin
      r = 2 * n - 1 - i;
    end
    if (r < 0) r = 0;
    if (r >= n) r = n - 1;
    return r;
  endfunction

  function automatic int store_index(int r, int c, int ch);
    return ((r % LINES) * MAX_COLS + (c % MAX_COLS)) * CHANNELS + (ch % CHANNELS);
  endfunction

  function automatic int kernel_half();
    int h;
    h = kernel_sz / 2;
    if (h > MAX_HALF) h = MAX_HALF;
    return h;
  endfunction

  function automatic int coef_value(int kr, int kc);
    logic [COEF_W-1:0] raw;
    raw = kern_rows[kr][COEF_W*kc +: COEF_W];
    return int'($signed(raw));
  endfunction

  // weighted window sum in Q.8
  function automatic logic signed [SUM_W-1:0] predict_window_sum(int row, int col, int ch);
    int h;
    int kr;
    int kc;
    int rr;
    int cc;
    int acc;
    h = kernel_half();
    acc = 0;
    for (kr = 0; kr <= 2 * h; kr++) begin
      rr = reflect_index(row - h + kr, img_rows);
      for (kc = 0; kc <= 2 * h; kc++) begin
        cc = reflect_index(col - h + kc, img_cols);
        acc += int'(pix_mem[store_index(rr, cc, ch)]) * coef_value(kr, kc);
      end
    end
    return SUM_W'(acc);
  endfunction

  function automatic logic [59:0] rand60();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[59:0];
  endfunction

  function automatic logic [59:0] coef_row(coef_mode_e mode);
    logic [59:0] w;
    int k;
    w = rand60();
    for (k = 0; k < 5; k++) begin
      case (mode)
        COEF_ALL_MAX: w[COEF_W*k +: COEF_W] = 12'h7FF;
        COEF_ALL_MIN: w[COEF_W*k +: COEF_W] = 12'h800;
        COEF_MIXED: begin
          case ($urandom_range(0, 5))
            0: w[COEF_W*k +: COEF_W] = 12'h7FF;
            1: w[COEF_W*k +: COEF_W] = 12'h800;
            2: w[COEF_W*k +: COEF_W] = 12'h000;
            3: w[COEF_W*k +: COEF_W] = 12'hFFF;
            4: w[COEF_W*k +: COEF_W] = 12'h100;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    return w;
  endfunction

  function automatic int pick_pixel();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // anchors mostly at the borders or in a small corner so taps get reused
  function automatic int pick_anchor(int n, int field_max);
    int lim;
    int v;
    lim = (n == 0) ? 1 : n;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 1;
      2: v = lim - 1;
      3: v = lim - 2;
      4: v = lim;
      5, 6: v = $urandom_range(0, ((lim < 16) ? lim : 16) - 1);
      default: v = $urandom_range(0, field_max);
    endcase
    if (v < 0) v = 0;
    if (v > field_max) v = field_max;
    return v;
  endfunction

  // one register write beat; the write enable is lowered by the next item
  task automatic program_reg(cfg_idx_e idx, logic [59:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_IMAGE_ROWS:  img_rows  = int'(data[IMG_ROWS_W-1:0]);
      CFG_IMAGE_COLS:  img_cols  = int'(data[IMG_COLS_W-1:0]);
      CFG_KERNEL_SIZE: kernel_sz = int'(data[KSIZE_W-1:0]);
      default:         kern_rows[int'(idx) - int'(CFG_COEF_ROW_0)] = data;
    endcase
  endtask

  // one item beat, held until accepted; then the sender's burst and gap pattern
  task automatic issue_item(logic kind, int row, int col, int ch, int pix,
                            bit typed, int typed_sum);
    int gap;
    int idx;
    if (cfg_we_i) cfg_we_i <= 1'b0;
    start     <= 1'b1;
    kind_i    <= kind;
    row_i     <= ROW_IN_W'(row);
    col_i     <= COL_IN_W'(col);
    channel_i <= CH_IN_W'(ch);
    pixel_i   <= PIX_W'(pix);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    work_since_idle = 1'b1;
    items_total++;
    if (kind == KIND_WRITE) begin
      idx = store_index(row, col, ch);
      pix_mem[idx]   = 8'(pix);
      pix_valid[idx] = 1'b1;
      pixel_writes++;
    end else begin
      pending_sums.push_back(typed ? SUM_W'(typed_sum) : predict_window_sum(row, col, ch));
      window_sums++;
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
    end
  endtask

  // writes every window tap not yet stored, so no unwritten entry is read
  task automatic ensure_taps(int row, int col, int ch);
    int h;
    int kr;
    int kc;
    int rr;
    int cc;
    h = kernel_half();
    for (kr = 0; kr <= 2 * h; kr++) begin
      rr = reflect_index(row - h + kr, img_rows);
      for (kc = 0; kc <= 2 * h; kc++) begin
        cc = reflect_index(col - h + kc, img_cols);
        if (!pix_valid[store_index(rr, cc, ch)]) begin
          issue_item(KIND_WRITE, (rr % LINES) + LINES * $urandom_range(0, 4096 / LINES - 1),
                     cc % MAX_COLS, ch, pick_pixel(), 1'b0, 0);
        end
      end
    end
  endtask

  // wait for every result, then let the pipeline run empty
  task automatic settle_block();
    if (work_since_idle) begin
      if (start) start <= 1'b0;
      @(posedge clk_i);
      while (pending_sums.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      work_since_idle = 1'b0;
    end
  endtask

  task automatic add_row(dir_op_e op, int row, int col, int ch, int pix,
                         cfg_idx_e idx, logic [59:0] data, bit typed, int sum);
    dir_row_t r;
    r.op    = op;
    r.row   = row;
    r.col   = col;
    r.ch    = ch;
    r.pix   = pix;
    r.idx   = idx;
    r.data  = data;
    r.typed = typed;
    r.sum   = sum;
    dir_rows.push_back(r);
  endtask

  // one register setting followed by random writes and window sums
  task automatic run_phase(int rows, int cols, int ks, coef_mode_e mode);
    int base;
    int k;
    int ar;
    int ac;
    int ch;
    bit paused;
    logic [59:0] d;
    settle_block();
    d = rand60();
    d[IMG_ROWS_W-1:0] = IMG_ROWS_W'(rows);
    program_reg(CFG_IMAGE_ROWS, d);
    d = rand60();
    d[IMG_COLS_W-1:0] = IMG_COLS_W'(cols);
    program_reg(CFG_IMAGE_COLS, d);
    d = rand60();
    d[KSIZE_W-1:0] = KSIZE_W'(ks);
    program_reg(CFG_KERNEL_SIZE, d);
    for (k = 0; k < COEF_ROWS; k++) begin
      program_reg(cfg_idx_e'(int'(CFG_COEF_ROW_0) + k), coef_row(mode));
    end
    settings_run++;
    base   = items_total;
    paused = 1'b0;
    while (items_total - base < PHASE_ITEMS) begin
      // hold the sender off once until the block has delivered everything
      if (!paused && items_total - base >= PHASE_ITEMS / 2) begin
        paused = 1'b1;
        if (start) start <= 1'b0;
        @(posedge clk_i);
        while (pending_sums.size() != 0) @(posedge clk_i);
      end
      ch = $urandom_range(0, CHANNELS - 1);
      if ($urandom_range(0, 99) < 35) begin
        ar = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 15);
        ac = $urandom_range(0, 1) ? $urandom_range(0, 2047) : $urandom_range(0, 31);
        issue_item(KIND_WRITE, ar, ac, ch, pick_pixel(), 1'b0, 0);
      end else begin
        ar = pick_anchor(img_rows, 4095);
        ac = pick_anchor(img_cols, 2047);
        ensure_taps(ar, ac, ch);
        issue_item(KIND_SUM, ar, ac, ch, pick_pixel(), 1'b0, 0);
      end
    end
  endtask

  // result beats, compared with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("result %0d with none outstanding", weighted_sum_o));
      end else begin
        oldest_sum = pending_sums.pop_front();
        sums_checked++;
        if (weighted_sum_o !== oldest_sum) begin
          report_mismatch($sformatf("weighted_sum %0d, predicted %0d",
                                    weighted_sum_o, oldest_sum));
        end
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("run limit of %0d cycles reached, %0d sums outstanding",
             CYCLE_LIMIT, pending_sums.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int i;
    dir_row_t r;

    rst_ni     = 1'b0;
    start      = 1'b0;
    kind_i     = KIND_WRITE;
    row_i      = '0;
    col_i      = '0;
    channel_i  = '0;
    pixel_i    = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_IMAGE_ROWS;
    cfg_data_i = '0;

    img_rows  = int'(IMG_ROWS_RST);
    img_cols  = int'(IMG_COLS_RST);
    kernel_sz = int'(KSIZE_RST);
    for (i = 0; i < COEF_ROWS; i++) kern_rows[i] = '0;
    mismatch_count  = 0;
    items_total     = 0;
    pixel_writes    = 0;
    window_sums     = 0;
    sums_checked    = 0;
    settings_run    = 0;
    burst_left      = 1;
    work_since_idle = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset setting gives zero, then single-tap extremes
    add_row(DOP_PIXEL, 0, 0, 0, 255, CFG_IMAGE_ROWS, '0, 1'b0, 0);
    add_row(DOP_PIXEL, 0, 1, 0, 0, CFG_IMAGE_ROWS, '0, 1'b0, 0);
    add_row(DOP_PIXEL, 1, 0, 0, 128, CFG_IMAGE_ROWS, '0, 1'b0, 0);
    add_row(DOP_PIXEL, 1, 1, 0, 1, CFG_IMAGE_ROWS, '0, 1'b0, 0);
    add_row(DOP_SUM, 0, 0, 0, 0, CFG_IMAGE_ROWS, '0, 1'b1, 0);
    add_row(DOP_REG, 0, 0, 0, 0, CFG_KERNEL_SIZE, 60'd1, 1'b0, 0);
    add_row(DOP_REG, 0, 0, 0, 0, CFG_COEF_ROW_0, 60'h7FF, 1'b0, 0);
    add_row(DOP_SUM, 0, 0, 0, 0, CFG_IMAGE_ROWS, '0, 1'b1, 521985);
    add_row(DOP_REG, 0, 0, 0, 0, CFG_COEF_ROW_0, 60'h800, 1'b0, 0);
    add_row(DOP_SUM, 0, 0, 0, 0, CFG_IMAGE_ROWS, '0, 1'b1, -522240);
    add_row(DOP_SUM, 0, 1, 0, 0, CFG_IMAGE_ROWS, '0, 1'b1, 0);
    // smallest image with the widest kernel, anchor far outside
    add_row(DOP_REG, 0, 0, 0, 0, CFG_IMAGE_ROWS, 60'd2, 1'b0, 0);
    add_row(DOP_REG, 0, 0, 0, 0, CFG_IMAGE_COLS, 60'd2, 1'b0, 0);
    add_row(DOP_REG, 0, 0, 0, 0, CFG_KERNEL_SIZE, 60'd5, 1'b0, 0);
    for (i = 0; i < COEF_ROWS; i++) begin
      add_row(DOP_REG, 0, 0, 0, 0, cfg_idx_e'(int'(CFG_COEF_ROW_0) + i),
              coef_row(COEF_MIXED), 1'b0, 0);
    end
    add_row(DOP_SUM, 0, 0, 0, 0, CFG_IMAGE_ROWS, '0, 1'b0, 0);
    add_row(DOP_SUM, 1, 1, 0, 0, CFG_IMAGE_ROWS, '0, 1'b0, 0);
    add_row(DOP_SUM, 4095, 2047, 0, 0, CFG_IMAGE_ROWS, '0, 1'b0, 0);
    // oversize, zero and even kernel sides
    add_row(DOP_REG, 0, 0, 0, 0, CFG_KERNEL_SIZE, 60'd7, 1'b0, 0);
    add_row(DOP_SUM, 1, 0, 0, 0, CFG_IMAGE_ROWS, '0, 1'b0, 0);
    add_row(DOP_REG, 0, 0, 0, 0, CFG_KERNEL_SIZE, 60'd0, 1'b0, 0);
    add_row(DOP_SUM, 0, 1, 0, 0, CFG_IMAGE_ROWS, '0, 1'b0, 0);
    add_row(DOP_REG, 0, 0, 0, 0, CFG_KERNEL_SIZE, 60'd4, 1'b0, 0);
    add_row(DOP_SUM, 1, 1, 0, 0, CFG_IMAGE_ROWS, '0, 1'b0, 0);
    // largest image the anchor fields reach, far corner, last channel
    add_row(DOP_REG, 0, 0, 0, 0, CFG_IMAGE_ROWS, 60'd4096, 1'b0, 0);
    add_row(DOP_REG, 0, 0, 0, 0, CFG_IMAGE_COLS, 60'd2048, 1'b0, 0);
    add_row(DOP_REG, 0, 0, 0, 0, CFG_KERNEL_SIZE, 60'd1, 1'b0, 0);
    add_row(DOP_PIXEL, 4095, 2047, 3, 255, CFG_IMAGE_ROWS, '0, 1'b0, 0);
    add_row(DOP_SUM, 4095, 2047, 3, 0, CFG_IMAGE_ROWS, '0, 1'b0, 0);
    // zero image size acts as one
    add_row(DOP_REG, 0, 0, 0, 0, CFG_IMAGE_ROWS, 60'd0, 1'b0, 0);
    add_row(DOP_REG, 0, 0, 0, 0, CFG_IMAGE_COLS, 60'd0, 1'b0, 0);
    add_row(DOP_REG, 0, 0, 0, 0, CFG_KERNEL_SIZE, 60'd3, 1'b0, 0);
    add_row(DOP_SUM, 5, 9, 0, 0, CFG_IMAGE_ROWS, '0, 1'b0, 0);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      case (r.op)
        DOP_PIXEL: issue_item(KIND_WRITE, r.row, r.col, r.ch, r.pix, 1'b0, 0);
        DOP_SUM: begin
          ensure_taps(r.row, r.col, r.ch);
          issue_item(KIND_SUM, r.row, r.col, r.ch, 0, r.typed, r.sum);
        end
        default: begin
          settle_block();
          program_reg(r.idx, r.data);
        end
      endcase
    end

    // random phases: extremes of every register first
    run_phase(2, 2, 1, COEF_RANDOM);
    run_phase(4096, 2048, 5, COEF_ALL_MAX);
    run_phase(4096, 2048, 5, COEF_ALL_MIN);
    run_phase(0, 0, 0, COEF_MIXED);
    run_phase(8191, 4095, 7, COEF_MIXED);
    run_phase(3, 5, 2, COEF_RANDOM);
    run_phase(480, 640, 3, COEF_MIXED);
    run_phase($urandom_range(2, 40), $urandom_range(2, 300), $urandom_range(0, 7), COEF_RANDOM);

    settle_block();

    $display("covered %0d items: %0d pixel writes and %0d window sums, %0d results checked",
             items_total, pixel_writes, window_sums, sums_checked);
    $display("%0d register settings beyond the directed part, %0d mismatches",
             settings_run, mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/c2drb_pkg.sv
rtl/core/c2drb_tapgen.sv
rtl/core/c2drb_addr.sv
rtl/core/c2drb_ram.sv
rtl/core/c2drb_mac.sv
rtl/core/conv2d_reflect_border_core.sv
rtl/core/c2drb_checker.sv
tb/sv/conv2d_reflect_border_core_test.sv
